// ===== hw/rtl/bmci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmci_pkg;

  // Default number of significant program ROM bank bits
  localparam int PRG_BANK_BITS_DEF = 6;

  // Register file commands
  localparam logic [3:0] CMD_MIRROR   = 4'hC;
  localparam logic [3:0] CMD_IRQ_CTRL = 4'hD;
  localparam logic [3:0] CMD_CNT_LO   = 4'hE;
  localparam logic [3:0] CMD_CNT_HI   = 4'hF;

  // CPU address regions (address bits 15:13)
  localparam logic [2:0] REGION_CMD  = 3'b100;
  localparam logic [2:0] REGION_DATA = 3'b101;

  // Program target codes
  localparam logic [1:0] TGT_ROM     = 2'd0;
  localparam logic [1:0] TGT_RAM     = 2'd1;
  localparam logic [1:0] TGT_OPEN    = 2'd2;
  localparam logic [1:0] TGT_NONCART = 2'd3;

  // $6000 window modes (prg bank 0, bits 7:6)
  localparam logic [1:0] WMODE_OPEN = 2'b01;
  localparam logic [1:0] WMODE_RAM  = 2'b11;

  // Mirroring modes
  localparam logic [1:0] MIR_VERT = 2'd0;
  localparam logic [1:0] MIR_HORZ = 2'd1;
  localparam logic [1:0] MIR_ONE0 = 2'd2;

  localparam logic [15:0] CNT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [15:0] cpu_address;
    logic        cpu_is_write;
    logic [7:0]  cpu_wdata;
    logic [13:0] ppu_address;
  } cyc_word_t;

  typedef struct packed {
    logic [1:0]  prg_target;
    logic [18:0] prg_address;
    logic [17:0] chr_address;
    logic        is_nametable;
    logic        nametable_a10;
    logic        irq_level;
  } res_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bank_mapper_cycle_irq.sv =====
// An accepted bus-cycle word is held in the input register, its result word in
// the result register. Throughput: one word per cycle unless res_ready stalls;
// the register update and address translation for a word sit between the two.
// Reset (synchronous, rst high): banks, command, mirroring and IRQ control
// clear, the IRQ counter loads $FFFF and both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none
module bank_mapper_cycle_irq #(
  parameter int PRG_BANK_BITS = bmci_pkg::PRG_BANK_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cyc_valid,
  output logic                 cyc_ready,
  input  bmci_pkg::cyc_word_t  cyc,
  output logic                 res_valid,
  input  wire                  res_ready,
  output bmci_pkg::res_word_t  res
);
  import bmci_pkg::*;

  localparam logic [8:0] BANK_MASK_W = 9'((10'd1 << PRG_BANK_BITS) - 10'd1);
  localparam logic [7:0] BANK_MASK   = BANK_MASK_W[7:0];

  // Mapper state
  logic [3:0]  command_reg;
  logic [7:0]  chr_banks [8];
  logic [7:0]  prg_banks [4];
  logic [1:0]  mirror_mode;
  logic [15:0] irq_count;
  logic [7:0]  irq_ctrl;
  logic        irq_pending;

  // Pipeline registers
  logic       s1_valid;
  cyc_word_t  s1;
  logic       s1_move;

  assign s1_move   = s1_valid && (!res_valid || res_ready);
  assign cyc_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cyc_ready) begin
      s1_valid <= cyc_valid;
    end
    if (cyc_ready && cyc_valid) begin
      s1 <= cyc;
    end
  end

  // Register write decode
  logic [2:0]  region;
  logic        wr_cmd, wr_data;
  logic [3:0]  command_next;
  logic [7:0]  chr_next [8];
  logic [7:0]  prg_next [4];
  logic [1:0]  mirror_next;
  logic [7:0]  ctrl_w, irq_ctrl_next;
  logic [15:0] cnt_w, irq_count_next;
  logic        pend_w, irq_pending_next;

  assign region  = s1.cpu_address[15:13];
  assign wr_cmd  = s1.cpu_is_write && (region == REGION_CMD);
  assign wr_data = s1.cpu_is_write && (region == REGION_DATA);

  always_comb begin
    command_next = command_reg;
    chr_next     = chr_banks;
    prg_next     = prg_banks;
    mirror_next  = mirror_mode;
    ctrl_w       = irq_ctrl;
    cnt_w        = irq_count;
    pend_w       = irq_pending;
    if (wr_cmd) begin
      command_next = s1.cpu_wdata[3:0];
    end
    if (wr_data) begin
      if (!command_reg[3]) begin
        chr_next[command_reg[2:0]] = s1.cpu_wdata;
      end else if (!command_reg[2]) begin
        prg_next[command_reg[1:0]] = s1.cpu_wdata;
      end else begin
        case (command_reg)
          CMD_MIRROR: mirror_next = s1.cpu_wdata[1:0];
          CMD_IRQ_CTRL: begin
            ctrl_w = s1.cpu_wdata;
            if (!s1.cpu_wdata[0]) pend_w = 1'b0;
          end
          CMD_CNT_LO: cnt_w = {irq_count[15:8], s1.cpu_wdata};
          CMD_CNT_HI: cnt_w = {s1.cpu_wdata, irq_count[7:0]};
          default: ;
        endcase
      end
    end

    // Cycle tick: count down when enabled; at zero, fire if IRQ enabled and disarm
    irq_count_next   = ctrl_w[7] ? cnt_w - 16'd1 : cnt_w;
    irq_ctrl_next    = ctrl_w;
    irq_pending_next = pend_w;
    if (irq_count_next == 16'd0) begin
      if (ctrl_w[0]) irq_pending_next = 1'b1;
      irq_ctrl_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg <= 4'd0;
      for (int i = 0; i < 8; i++) chr_banks[i] <= 8'd0;
      for (int i = 0; i < 4; i++) prg_banks[i] <= 8'd0;
      mirror_mode <= MIR_VERT;
      irq_count   <= CNT_RESET;
      irq_ctrl    <= 8'd0;
      irq_pending <= 1'b0;
    end else if (s1_move) begin
      command_reg <= command_next;
      chr_banks   <= chr_next;
      prg_banks   <= prg_next;
      mirror_mode <= mirror_next;
      irq_count   <= irq_count_next;
      irq_ctrl    <= irq_ctrl_next;
      irq_pending <= irq_pending_next;
    end
  end

  // Address translation on post-write register values
  res_word_t  res_next;
  logic [1:0] win;
  logic [7:0] rom_bank;
  logic [1:0] wmode;
  logic [7:0] chr_bank;

  always_comb begin
    res_next = '0;
    win      = s1.cpu_address[14:13];
    wmode    = prg_next[0][7:6];
    rom_bank = 8'hFF;
    chr_bank = chr_next[s1.ppu_address[12:10]];

    // CPU side
    res_next.prg_target = TGT_NONCART;
    if (s1.cpu_address[15]) begin
      if (win != 2'd3) rom_bank = prg_next[2'(win + 2'd1)];
      rom_bank = rom_bank & BANK_MASK;
      res_next.prg_target  = TGT_ROM;
      res_next.prg_address = {rom_bank[5:0], s1.cpu_address[12:0]};
    end else if (s1.cpu_address[14:13] == 2'b11) begin
      if (wmode == WMODE_OPEN) begin
        res_next.prg_target = TGT_OPEN;
      end else if (wmode == WMODE_RAM) begin
        res_next.prg_target  = TGT_RAM;
        res_next.prg_address = {6'd0, s1.cpu_address[12:0]};
      end else begin
        rom_bank = prg_next[0] & 8'h3F & BANK_MASK;
        res_next.prg_target  = TGT_ROM;
        res_next.prg_address = {rom_bank[5:0], s1.cpu_address[12:0]};
      end
    end

    // PPU side
    if (!s1.ppu_address[13]) begin
      res_next.chr_address = {chr_bank, s1.ppu_address[9:0]};
    end else begin
      res_next.is_nametable = 1'b1;
      case (mirror_next)
        MIR_VERT: res_next.nametable_a10 = s1.ppu_address[10];
        MIR_HORZ: res_next.nametable_a10 = s1.ppu_address[11];
        MIR_ONE0: res_next.nametable_a10 = 1'b0;
        default:  res_next.nametable_a10 = 1'b1;
      endcase
    end

    res_next.irq_level = irq_pending_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= s1_valid;
    end
    if (s1_move) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== dv/bank_mapper_cycle_irq_tb.sv =====
`timescale 1ns / 1ps
module bank_mapper_cycle_irq_tb;
  import bmci_pkg::*;

  localparam int PRG_BITS = PRG_BANK_BITS_DEF;
  // Bank commands that the package does not name
  localparam logic [3:0] CMD_CHR_LAST = 4'h7;
  localparam logic [3:0] CMD_PRG_WIN6 = 4'h8;
  localparam logic [7:0] TOP_BANK     = 8'hFF;
  localparam logic [7:0] WIN6_BANK_MASK = 8'h3F;

  localparam int RANDOM_WORDS  = 2000;
  localparam int IDLE_PCT      = 38;
  localparam int QUIET_FROM    = 1200;
  localparam int QUIET_TO      = 1500;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 20;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // Predicts the translation word for each accepted bus cycle and checks results
  class mapping_scoreboard;
    logic [3:0]  command;
    logic [7:0]  chr_bank [8];
    logic [7:0]  prg_bank [4];
    logic [1:0]  mirror;
    logic [15:0] count;
    logic [7:0]  ctrl;
    logic        irq;
    res_word_t   translations_due [$];
    int          errors;
    int          checked;
    int          irq_rises;

    function new();
      command = '0;
      foreach (chr_bank[i]) chr_bank[i] = '0;
      foreach (prg_bank[i]) prg_bank[i] = '0;
      mirror    = MIR_VERT;
      count     = CNT_RESET;
      ctrl      = '0;
      irq       = 1'b0;
      errors    = 0;
      checked   = 0;
      irq_rises = 0;
    endfunction

    function logic [18:0] rom_offset(logic [7:0] bank, logic [12:0] offset);
      logic [31:0] wide;
      wide = ((32'(bank) & ((32'd1 << PRG_BITS) - 32'd1)) << 13) | 32'(offset);
      return wide[18:0];
    endfunction

    function int outstanding();
      return translations_due.size();
    endfunction

    function void note_cycle(cyc_word_t w);
      res_word_t   e;
      logic [1:0]  win;
      logic [7:0]  bank;
      logic        was_irq;
      logic [13:0] pa;
      was_irq = irq;
      pa = w.ppu_address;

      // register write, ahead of the tick
      if (w.cpu_is_write) begin
        if (w.cpu_address[15:13] == REGION_CMD) begin
          command = w.cpu_wdata[3:0];
        end else if (w.cpu_address[15:13] == REGION_DATA) begin
          case (command)
            CMD_MIRROR: mirror = w.cpu_wdata[1:0];
            CMD_IRQ_CTRL: begin
              ctrl = w.cpu_wdata;
              if (!w.cpu_wdata[0]) irq = 1'b0;
            end
            CMD_CNT_LO: count[7:0] = w.cpu_wdata;
            CMD_CNT_HI: count[15:8] = w.cpu_wdata;
            default: begin
              if (!command[3]) chr_bank[command[2:0]] = w.cpu_wdata;
              else prg_bank[command[1:0]] = w.cpu_wdata;
            end
          endcase
        end
      end

      // cycle tick; the zero check runs even with counting off
      if (ctrl[7]) count = count - 16'd1;
      if (count == 16'd0) begin
        if (ctrl[0]) irq = 1'b1;
        ctrl = '0;
      end
      if (irq && !was_irq) irq_rises++;

      // CPU side
      e = '0;
      e.prg_target = TGT_NONCART;
      if (w.cpu_address[15]) begin
        win = w.cpu_address[14:13];
        bank = (win == 2'd3) ? TOP_BANK : prg_bank[2'(win + 2'd1)];
        e.prg_target  = TGT_ROM;
        e.prg_address = rom_offset(bank, w.cpu_address[12:0]);
      end else if (w.cpu_address[14:13] == 2'b11) begin
        case (prg_bank[0][7:6])
          WMODE_OPEN: e.prg_target = TGT_OPEN;
          WMODE_RAM: begin
            e.prg_target  = TGT_RAM;
            e.prg_address = {6'd0, w.cpu_address[12:0]};
          end
          default: begin
            e.prg_target  = TGT_ROM;
            e.prg_address = rom_offset(prg_bank[0] & WIN6_BANK_MASK, w.cpu_address[12:0]);
          end
        endcase
      end

      // PPU side
      if (!pa[13]) begin
        e.chr_address = {chr_bank[pa[12:10]], pa[9:0]};
      end else begin
        e.is_nametable = 1'b1;
        case (mirror)
          MIR_VERT: e.nametable_a10 = pa[10];
          MIR_HORZ: e.nametable_a10 = pa[11];
          MIR_ONE0: e.nametable_a10 = 1'b0;
          default:  e.nametable_a10 = 1'b1;
        endcase
      end
      e.irq_level = irq;
      translations_due.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH result %0d %s: got %0h, predicted %0h", checked, what, got, want);
      errors++;
    endtask

    task check_result(res_word_t r);
      res_word_t e;
      if (translations_due.size() == 0) begin
        report_mismatch("unexpected result word", 32'(r), 32'd0);
      end else begin
        e = translations_due.pop_front();
        if (r.prg_target !== e.prg_target)
          report_mismatch("prg_target", 32'(r.prg_target), 32'(e.prg_target));
        if (r.prg_address !== e.prg_address)
          report_mismatch("prg_address", 32'(r.prg_address), 32'(e.prg_address));
        if (r.chr_address !== e.chr_address)
          report_mismatch("chr_address", 32'(r.chr_address), 32'(e.chr_address));
        if (r.is_nametable !== e.is_nametable)
          report_mismatch("is_nametable", 32'(r.is_nametable), 32'(e.is_nametable));
        if (r.nametable_a10 !== e.nametable_a10)
          report_mismatch("nametable_a10", 32'(r.nametable_a10), 32'(e.nametable_a10));
        if (r.irq_level !== e.irq_level)
          report_mismatch("irq_level", 32'(r.irq_level), 32'(e.irq_level));
      end
      checked++;
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cyc_valid;
  logic      cyc_ready;
  cyc_word_t cyc;
  logic      res_valid;
  logic      res_ready;
  res_word_t res;

  mapping_scoreboard sb;
  int   words_sent;
  bit   idle_on;
  bit   hold_off_req;

  bank_mapper_cycle_irq i_dut (
    .clk       (clk),
    .rst       (rst),
    .cyc_valid (cyc_valid),
    .cyc_ready (cyc_ready),
    .cyc       (cyc),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #10 clk = ~clk;

  // Watch both channels; values sampled here are those from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cyc_valid && cyc_ready) sb.note_cycle(cyc);
      if (res_valid && res_ready) sb.check_result(res);
    end
  end

  // Result side: random back-pressure plus a long hold-off on each request
  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one bus-cycle word, holding it until accepted
  task automatic put(input logic [15:0] addr, input logic wr, input logic [7:0] data,
                     input logic [13:0] ppu);
    cyc_word_t w;
    w.cpu_address  = addr;
    w.cpu_is_write = wr;
    w.cpu_wdata    = data;
    w.ppu_address  = ppu;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      cyc_valid <= 1'b0;
      @(posedge clk);
    end
    cyc       <= w;
    cyc_valid <= 1'b1;
    @(posedge clk);
    while (!cyc_ready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [13:0] any_ppu();
    return 14'($urandom_range(0, 16383));
  endfunction

  // Command select followed by a data write, at random offsets in each region
  task automatic reg_write(input logic [3:0] cmd, input logic [7:0] data);
    put({REGION_CMD, 13'($urandom_range(0, 8191))}, 1'b1,
        {4'($urandom_range(0, 15)), cmd}, any_ppu());
    put({REGION_DATA, 13'($urandom_range(0, 8191))}, 1'b1, data, any_ppu());
  endtask

  initial begin
    int          directed;
    int          pick;
    logic [3:0]  cmd;
    logic [7:0]  data;
    logic [15:0] addr;
    rst          = 1'b1;
    cyc_valid    = 1'b0;
    cyc          = '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    words_sent   = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: address extremes, each register kind, window modes, IRQ paths
    put(16'h0000, 1'b0, 8'h00, 14'h0000);
    put(16'hFFFF, 1'b0, 8'hFF, 14'h3FFF);
    reg_write(CMD_CHR_LAST, 8'hFF);
    put(16'h6000, 1'b0, 8'h5A, 14'h1FFF);
    reg_write(CMD_PRG_WIN6, 8'hC0);              // work RAM window
    put(16'h7FFF, 1'b0, 8'h00, 14'h1C00);
    reg_write(CMD_PRG_WIN6, 8'h7F);              // open bus window
    put(16'h6ABC, 1'b0, 8'h00, 14'h0400);
    reg_write(CMD_MIRROR, 8'hFD);                // upper bits dropped: horizontal
    put(16'hC000, 1'b1, 8'h0E, 14'h2800);        // write outside the register space
    reg_write(CMD_CNT_LO, 8'h03);
    reg_write(CMD_CNT_HI, 8'h00);
    reg_write(CMD_IRQ_CTRL, 8'h81);
    put(16'h8000, 1'b0, 8'h00, 14'h2400);
    put(16'hE000, 1'b0, 8'h00, 14'h3000);        // counter reaches zero here
    put({REGION_DATA, 13'h0000}, 1'b1, 8'h00, 14'h0000);  // clear enable drops IRQ
    put({REGION_DATA, 13'h1FFF}, 1'b1, 8'h01, 14'h2000);  // zero count, counting off
    put({REGION_DATA, 13'h0AAA}, 1'b1, 8'h80, 14'h3C00);  // wraps past zero
    directed = words_sent;

    // Random: mostly well-formed register writes and reads, some noise
    while (words_sent < directed + RANDOM_WORDS) begin
      idle_on = !(words_sent >= directed + QUIET_FROM && words_sent < directed + QUIET_TO);
      if (words_sent >= directed + HOLD_AT && words_sent < directed + HOLD_AT + 3)
        hold_off_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 50) begin
        cmd  = 4'($urandom_range(0, 15));
        data = 8'($urandom);
        case (cmd)
          CMD_CNT_HI: if ($urandom_range(1) == 0) data = 8'h00;
          CMD_CNT_LO: if ($urandom_range(9) < 7) data = 8'($urandom_range(0, 15));
          CMD_IRQ_CTRL: begin
            data[7] = ($urandom_range(3) != 0);
            data[0] = ($urandom_range(3) != 0);
          end
          default: ;
        endcase
        reg_write(cmd, data);
      end else if (pick < 85) begin
        if ($urandom_range(9) < 7) addr = 16'($urandom_range(16'h6000, 16'hFFFF));
        else addr = 16'($urandom_range(0, 16'hFFFF));
        put(addr, 1'b0, 8'($urandom), any_ppu());
      end else begin
        put(16'($urandom), 1'b1, 8'($urandom), any_ppu());
      end
    end
    cyc_valid <= 1'b0;
    idle_on = 1'b1;

    // Drain the pipeline
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bus-cycle words (%0d directed) and checked %0d result words.",
             words_sent, directed, sb.checked);
    $display("The counter raised the IRQ line %0d times; %0d mismatches in total.",
             sb.irq_rises, sb.errors);
    if (sb.errors == 0) begin
      $display("bank_mapper_cycle_irq regression: pass");
    end else begin
      $display("bank_mapper_cycle_irq regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d result words outstanding", sb.outstanding());
    $display("bank_mapper_cycle_irq regression: fail");
    $finish;
  end

endmodule

// ===== bank_mapper_cycle_irq.f =====
hw/rtl/bmci_pkg.sv
hw/rtl/bank_mapper_cycle_irq.sv
dv/bank_mapper_cycle_irq_tb.sv
